>>> rtl/core/mvf_pkg.sv
`timescale 1ns / 1ps

package mvf_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MAX_LEVEL    = 255;
    localparam int VOL_W        = 8;
    localparam int SPAN_W       = 24;
    localparam int TIME_W       = 32;

    typedef enum logic [1:0] {
        OP_SET_NOW  = 2'd0,
        OP_SET_FADE = 2'd1,
        OP_TICK     = 2'd2,
        OP_READ     = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SLOT = 2'd1;
    localparam logic [1:0] ST_BAD_VOL = 2'd2;

    // One stored fade; the span equals the fade length since it is below 2^24.
    typedef struct packed {
        logic [TIME_W-1:0] begin_ms;
        logic [SPAN_W-1:0] span;
        logic [VOL_W-1:0]  vol0;
        logic [VOL_W-1:0]  target;
    } t_fade_rec;

    typedef struct packed {
        logic              start;
        logic [VOL_W-1:0]  vol0;
        logic [VOL_W-1:0]  target;
        logic [SPAN_W-1:0] elapsed;
        logic [SPAN_W-1:0] span;
    } t_calc_req;

    typedef struct packed {
        logic             done;
        logic [VOL_W-1:0] volume;
    } t_calc_rsp;

endpackage

>>> rtl/core/mvf_ram.sv
`timescale 1ns / 1ps

module mvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mvf_fade_calc.sv
`timescale 1ns / 1ps

module mvf_fade_calc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mvf_pkg::t_calc_req i_req,
    output mvf_pkg::t_calc_rsp o_rsp
);

    import mvf_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_DIV,
        C_FIN
    } t_cstate;

    localparam int PROD_W = VOL_W + SPAN_W;
    localparam int CNT_W  = $clog2(VOL_W);

    t_cstate            r_state;
    logic               r_neg;
    logic [VOL_W-1:0]   r_mag;
    logic [VOL_W-1:0]   r_v0;
    logic [SPAN_W-1:0]  r_e;
    logic [SPAN_W-1:0]  r_span;
    logic [SPAN_W-1:0]  r_rem;
    logic [VOL_W-1:0]   r_low;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [VOL_W-1:0]   r_res;

    logic [PROD_W-1:0]  w_prod;
    logic [SPAN_W:0]    w_trial;
    logic               w_fit;
    logic [SPAN_W:0]    w_diff;

    assign w_prod  = PROD_W'(r_mag) * PROD_W'(r_e);
    assign w_trial = {r_rem, r_low[VOL_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_span};
    assign w_diff  = w_trial - {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == C_FIN);
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_neg  <= i_req.target < i_req.vol0;
                        r_mag  <= (i_req.target < i_req.vol0) ? i_req.vol0 - i_req.target
                                                              : i_req.target - i_req.vol0;
                        r_v0   <= i_req.vol0;
                        r_e    <= i_req.elapsed;
                        r_span <= i_req.span;
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    // product is below 256 * span, so its upper part is a valid remainder
                    r_rem   <= w_prod[PROD_W-1:VOL_W];
                    r_low   <= w_prod[VOL_W-1:0];
                    r_cnt   <= '0;
                    r_state <= C_DIV;
                end
                C_DIV: begin
                    // one restoring step per cycle; quotient bits shift into r_low
                    r_rem <= w_fit ? w_diff[SPAN_W-1:0] : w_trial[SPAN_W-1:0];
                    r_low <= {r_low[VOL_W-2:0], w_fit};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(VOL_W - 1)) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    // falling fade rounds toward minus infinity
                    r_res   <= r_neg ? r_v0 - r_low - VOL_W'(r_rem != '0)
                                     : r_v0 + r_low;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.volume = r_res;

endmodule

>>> rtl/core/multichannel_volume_fader_unit.sv
`timescale 1ns / 1ps

// Volume store with one linear fade per slot: slots 0..CHANNELS-1 are channels,
// slot CHANNELS is the music slot.
// Input channel s_axis: one command word per transfer; the opcode travels on
// tuser (set now, set with fade, tick, read), slot, level, fade length and the
// current millisecond count on tdata.
// Output channel m_axis: exactly one result word per command, volume and status.
// The unit takes one command at a time: s_axis_tready is high only while it
// is idle. Set, fade and read commands post their result from S_EXEC once the
// output register is free. A tick walks all CHANNELS+1 slots
// through one shared multiply and restoring divider: an idle slot is only
// checked, a fade that has ended is checked, read and set to its target, and a
// fade in progress is checked, read, multiplied once, divided in 8 steps,
// finished and written back. After the last slot the walk posts the reply.
// Reset: all volumes read 255 and no fade is running; fade parameters live in
// a small RAM and are only used for slots with a running fade.
// Stall: a finished result is held in the output register until taken; the
// next command can be accepted meanwhile, but its own result waits for the
// register to free up.
module multichannel_volume_fader_unit #(
    parameter int CHANNELS = mvf_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // slot[4:0], level[13:5], fade_duration[37:14],
                                        // time_now[69:38], zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // volume[7:0], status[9:8], zero pad
);

    import mvf_pkg::*;

    localparam int NSLOTS = CHANNELS + 1;
    localparam int IW     = $clog2(NSLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_CHK,
        S_TICK_RD,
        S_TICK_CALC,
        S_REPLY
    } t_state;

    t_state              r_state;
    t_opcode             r_op;
    logic [4:0]          r_slot;
    logic [8:0]          r_level;
    logic [SPAN_W-1:0]   r_dur;
    logic [TIME_W-1:0]   r_now;
    logic [IW-1:0]       r_idx;
    logic [VOL_W-1:0]    r_vol [NSLOTS];
    logic                r_act [NSLOTS];
    logic                r_out_valid;
    logic [VOL_W-1:0]    r_out_vol;
    logic [1:0]          r_out_status;

    logic                w_out_free;
    logic                w_post;
    logic [IW-1:0]       w_addr;
    logic                w_music;
    logic [1:0]          w_status;
    logic [VOL_W-1:0]    w_rd_vol;
    logic                w_vol_we;
    logic                w_fade_we;
    t_fade_rec           w_wrec;
    t_fade_rec           w_rrec;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_ended;
    logic                w_last;
    t_calc_req           w_req;
    t_calc_rsp           w_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_post        = w_out_free && ((r_state == S_EXEC) || (r_state == S_REPLY));
    assign w_addr        = (r_state == S_EXEC) ? r_slot[IW-1:0] : r_idx;
    assign w_music       = (r_slot == 5'(CHANNELS));
    assign w_last        = (r_idx == IW'(NSLOTS - 1));

    // decode of the non-tick commands
    always_comb begin
        w_status  = ST_OK;
        w_rd_vol  = '0;
        w_vol_we  = 1'b0;
        w_fade_we = 1'b0;
        if (r_slot > 5'(CHANNELS)) begin
            w_status = ST_BAD_SLOT;
        end else begin
            case (r_op)
                OP_READ: begin
                    w_rd_vol = r_vol[w_addr];
                end
                OP_SET_NOW, OP_SET_FADE: begin
                    if (r_level > 9'(MAX_LEVEL)) begin
                        w_status = ST_BAD_VOL;
                    end else if (r_op == OP_SET_NOW) begin
                        w_vol_we = 1'b1;
                    end else if (w_music && r_dur == '0) begin
                        w_vol_we = 1'b1;
                    end else if (w_music || !r_act[w_addr]) begin
                        w_fade_we = 1'b1;
                    end
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
    end

    assign w_wrec.begin_ms = r_now;
    assign w_wrec.span     = r_dur;
    assign w_wrec.vol0     = r_vol[w_addr];
    assign w_wrec.target   = r_level[VOL_W-1:0];

    mvf_ram #(
        .WIDTH($bits(t_fade_rec)),
        .DEPTH(NSLOTS)
    ) u_fade_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_EXEC && w_out_free && w_fade_we),
        .i_waddr (r_slot[IW-1:0]),
        .i_wdata (w_wrec),
        .i_raddr (r_idx),
        .o_rdata (w_rrec)
    );

    assign w_elapsed = r_now - w_rrec.begin_ms;
    assign w_ended   = w_elapsed >= TIME_W'(w_rrec.span);

    assign w_req.start   = (r_state == S_TICK_RD) && !w_ended;
    assign w_req.vol0    = w_rrec.vol0;
    assign w_req.target  = w_rrec.target;
    assign w_req.elapsed = w_elapsed[SPAN_W-1:0];
    assign w_req.span    = w_rrec.span;

    mvf_fade_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < NSLOTS; i++) begin
                r_vol[i] <= VOL_W'(MAX_LEVEL);
                r_act[i] <= 1'b0;
            end
        end else begin
            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= t_opcode'(s_axis_tuser);
                        r_slot  <= s_axis_tdata[4:0];
                        r_level <= s_axis_tdata[13:5];
                        r_dur   <= s_axis_tdata[37:14];
                        r_now   <= s_axis_tdata[69:38];
                        r_idx   <= '0;
                        r_state <= (t_opcode'(s_axis_tuser) == OP_TICK) ? S_TICK_CHK : S_EXEC;
                    end
                end
                S_EXEC: begin
                    // hold until the output register can take the result
                    if (w_out_free) begin
                        if (w_vol_we) begin
                            r_vol[w_addr] <= r_level[VOL_W-1:0];
                        end
                        if (w_fade_we) begin
                            r_act[w_addr] <= 1'b1;
                        end
                        r_out_vol    <= w_rd_vol;
                        r_out_status <= w_status;
                        r_state      <= S_IDLE;
                    end
                end
                S_TICK_CHK: begin
                    if (r_act[w_addr]) begin
                        r_state <= S_TICK_RD;
                    end else if (w_last) begin
                        r_state <= S_REPLY;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_TICK_RD: begin
                    if (w_ended) begin
                        r_vol[w_addr] <= w_rrec.target;
                        r_act[w_addr] <= 1'b0;
                        r_idx         <= w_last ? r_idx : r_idx + IW'(1);
                        r_state       <= w_last ? S_REPLY : S_TICK_CHK;
                    end else begin
                        r_state <= S_TICK_CALC;
                    end
                end
                S_TICK_CALC: begin
                    if (w_rsp.done) begin
                        r_vol[w_addr] <= w_rsp.volume;
                        r_idx         <= w_last ? r_idx : r_idx + IW'(1);
                        r_state       <= w_last ? S_REPLY : S_TICK_CHK;
                    end
                end
                S_REPLY: begin
                    if (w_out_free) begin
                        r_out_vol    <= '0;
                        r_out_status <= ST_OK;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_status, r_out_vol};

`ifndef SYNTHESIS
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_TICK_CALC)
        else $error("divider finished outside of a tick walk");

    a_err_zero_vol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_status != ST_OK) |-> r_out_vol == '0)
        else $error("error result carries a volume");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK_CHK) |-> r_idx <= IW'(NSLOTS - 1))
        else $error("tick walk beyond last slot");

    a_reply_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPLY && w_out_free) |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("tick result not posted");
`endif

endmodule

>>> tb/multichannel_volume_fader_unit_test.sv
`timescale 1ns / 1ps

module multichannel_volume_fader_unit_test;

    import mvf_pkg::*;

    localparam int NCH        = CHANNELS_DEF;
    localparam int RAND_ITEMS = 1400;
    localparam int IDLE_PCT   = 30;

    typedef struct {
        t_opcode     op;
        logic [4:0]  slot;
        logic [8:0]  level;
        logic [23:0] dur;
        logic [31:0] now;
    } t_fader_cmd;

    typedef struct {
        logic [7:0] volume;
        logic [1:0] status;
    } t_fader_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [71:0] s_tdata = '0;   // slot[4:0], level[13:5], fade_duration[37:14],
                                 // time_now[69:38], zero pad
    logic [1:0]  s_tuser = OP_SET_NOW;  // opcode[1:0]
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_tdata;        // volume[7:0], status[9:8], zero pad

    t_fader_cmd    pending_cmds[$];
    t_fader_result expected_results[$];
    t_fader_result got_expected;

    // Shadow of the fader state.
    logic [7:0]  cur_vol[0:NCH];
    logic        fade_on[0:NCH];
    logic [31:0] fade_t0[0:NCH];
    logic [31:0] fade_t1[0:NCH];
    logic [7:0]  fade_v0[0:NCH];
    logic [7:0]  fade_tgt[0:NCH];

    int          mismatch_count = 0;
    int unsigned cyc_count = 0;
    logic        quiet_window;
    logic [31:0] gen_time;

    multichannel_volume_fader_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: %s", $realtime, msg);
    endtask

    function automatic t_fader_result apply_command(input t_fader_cmd c);
        t_fader_result r;
        logic [31:0]   elapsed;
        logic [31:0]   span;
        longint        diff;
        longint        num;
        longint        den;
        longint        q;
        longint        e;
        r.volume = '0;
        r.status = ST_OK;
        if (c.op == OP_TICK) begin
            for (int s = 0; s <= NCH; s++) begin
                if (fade_on[s]) begin
                    elapsed = c.now - fade_t0[s];
                    span    = fade_t1[s] - fade_t0[s];
                    if (elapsed >= span) begin
                        cur_vol[s] = fade_tgt[s];
                        fade_on[s] = 1'b0;
                    end else begin
                        diff = longint'(fade_tgt[s]) - longint'(fade_v0[s]);
                        e    = elapsed;
                        den  = span;
                        num  = diff * e;
                        q    = num / den;
                        // floor, not truncation, on a falling fade
                        if ((num % den) != 0 && num < 0) begin
                            q = q - 1;
                        end
                        cur_vol[s] = 8'(longint'(fade_v0[s]) + q);
                    end
                end
            end
        end else if (c.slot > NCH) begin
            r.status = ST_BAD_SLOT;
        end else if (c.op == OP_READ) begin
            r.volume = cur_vol[c.slot];
        end else if (c.level > MAX_LEVEL) begin
            r.status = ST_BAD_VOL;
        end else if (c.op == OP_SET_NOW) begin
            cur_vol[c.slot] = c.level[7:0];
        end else if (c.slot == NCH && c.dur == 0) begin
            cur_vol[c.slot] = c.level[7:0];
        end else if (c.slot == NCH || !fade_on[c.slot]) begin
            fade_on[c.slot]  = 1'b1;
            fade_t0[c.slot]  = c.now;
            fade_t1[c.slot]  = c.now + {8'b0, c.dur};
            fade_v0[c.slot]  = cur_vol[c.slot];
            fade_tgt[c.slot] = c.level[7:0];
        end
        return r;
    endfunction

    task automatic queue_cmd(input t_opcode op, input logic [4:0] slot,
                             input logic [8:0] level, input logic [23:0] dur,
                             input logic [31:0] now);
        t_fader_cmd c;
        c.op    = op;
        c.slot  = slot;
        c.level = level;
        c.dur   = dur;
        c.now   = now;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    function automatic logic [8:0] pick_level();
        if ($urandom_range(99) < 90) begin
            return 9'($urandom_range(255));
        end
        return 9'($urandom_range(511, 256));
    endfunction

    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
    end

    // the last fifth of each period of cyc_count runs with no idling on either side
    assign quiet_window = (cyc_count % 5000) >= 4000;

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(),
                                        apply_command(pending_cmds.pop_front()));
            end
            // hold the word until it is taken
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 &&
                    (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_tuser <= pending_cmds[0].op;
                    s_tdata <= {2'b0, pending_cmds[0].now, pending_cmds[0].dur,
                                pending_cmds[0].level, pending_cmds[0].slot};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", m_tdata));
            end else begin
                got_expected = expected_results.pop_front();
                if (m_tdata[7:0] !== got_expected.volume) begin
                    report_mismatch($sformatf("volume %0d, expected %0d",
                                              m_tdata[7:0], got_expected.volume));
                end
                if (m_tdata[9:8] !== got_expected.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tdata[9:8], got_expected.status));
                end
            end
        end
        m_ready <= quiet_window || $urandom_range(99) >= IDLE_PCT;
    end

    initial begin
        int          total;
        int          nfades;
        int          nticks;
        int          cls;
        int unsigned span_max;
        logic [23:0] dur;
        for (int s = 0; s <= NCH; s++) begin
            cur_vol[s]  = 8'(MAX_LEVEL);
            fade_on[s]  = 1'b0;
            fade_t0[s]  = '0;
            fade_t1[s]  = '0;
            fade_v0[s]  = '0;
            fade_tgt[s] = '0;
        end

        // reset values, bad slots, bad levels
        queue_cmd(OP_READ, 5'd0, 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_READ, 5'(NCH), 9'd511, 24'hFFFFFF, 32'hFFFFFFFF);
        queue_cmd(OP_READ, 5'(NCH + 1), 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_SET_NOW, 5'd31, 9'd511, 24'd0, 32'd0);
        queue_cmd(OP_SET_NOW, 5'd0, 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_SET_NOW, 5'(NCH - 1), 9'd255, 24'd0, 32'd0);
        queue_cmd(OP_SET_NOW, 5'd3, 9'd256, 24'd0, 32'd0);
        queue_cmd(OP_SET_FADE, 5'd3, 9'd511, 24'd10, 32'd0);
        queue_cmd(OP_READ, 5'd0, 9'd0, 24'd0, 32'd0);
        // rising fade across the time wrap, then a second fade that is ignored
        queue_cmd(OP_SET_FADE, 5'd0, 9'd255, 24'd1000, 32'hFFFFFE00);
        queue_cmd(OP_SET_FADE, 5'd0, 9'd7, 24'd5, 32'hFFFFFE00);
        // falling fade, floored toward minus infinity
        queue_cmd(OP_SET_FADE, 5'(NCH - 1), 9'd0, 24'd7, 32'hFFFFFFFE);
        // channel fade of zero length: the next tick ends it
        queue_cmd(OP_SET_FADE, 5'd5, 9'd77, 24'd0, 32'hFFFFFFFF);
        // music: zero length applies at once, then a long fade is replaced
        queue_cmd(OP_SET_FADE, 5'(NCH), 9'd10, 24'd0, 32'hFFFFFF00);
        queue_cmd(OP_SET_FADE, 5'(NCH), 9'd0, 24'hFFFFFF, 32'hFFFFFF00);
        queue_cmd(OP_SET_FADE, 5'(NCH), 9'd200, 24'd100, 32'hFFFFFFC0);
        queue_cmd(OP_TICK, 5'd31, 9'd511, 24'hFFFFFF, 32'h00000001);
        queue_cmd(OP_READ, 5'd0, 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_READ, 5'(NCH - 1), 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_READ, 5'd5, 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_READ, 5'(NCH), 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_SET_NOW, 5'(NCH), 9'd128, 24'd0, 32'd0);
        queue_cmd(OP_TICK, 5'd0, 9'd0, 24'd0, 32'h00001000);
        queue_cmd(OP_READ, 5'(NCH), 9'd0, 24'd0, 32'd0);
        queue_cmd(OP_READ, 5'd0, 9'd0, 24'd0, 32'd0);

        total    = pending_cmds.size() + RAND_ITEMS;
        gen_time = $urandom;
        while (pending_cmds.size() < total) begin
            if ($urandom_range(99) < 75) begin
                // fade episode: start a few fades, then tick through them
                if ($urandom_range(99) < 5) begin
                    gen_time = 32'hFFFFFFFF - $urandom_range(2000);
                end
                cls = $urandom_range(99);
                if (cls < 70) begin
                    span_max = 300;
                end else if (cls < 92) begin
                    span_max = 70000;
                end else begin
                    span_max = 24'hFFFFFF;
                end
                nfades = $urandom_range(5, 1);
                for (int i = 0; i < nfades; i++) begin
                    dur = ($urandom_range(99) < 4) ? 24'd0 : 24'($urandom_range(span_max, 1));
                    queue_cmd(OP_SET_FADE,
                              ($urandom_range(99) < 3) ? 5'($urandom_range(31, NCH + 1))
                                                       : 5'($urandom_range(NCH)),
                              pick_level(), dur, gen_time);
                    if ($urandom_range(99) < 15) begin
                        queue_cmd(OP_SET_NOW, 5'($urandom_range(NCH)), pick_level(),
                                  24'($urandom), $urandom);
                    end
                end
                nticks = $urandom_range(6, 1);
                for (int i = 0; i < nticks; i++) begin
                    gen_time = gen_time + $urandom_range(span_max / 3 + 1);
                    queue_cmd(OP_TICK, 5'($urandom), 9'($urandom), 24'($urandom), gen_time);
                    if ($urandom_range(1) == 1) begin
                        queue_cmd(OP_READ, 5'($urandom_range(NCH)), 9'($urandom),
                                  24'($urandom), $urandom);
                    end
                end
            end else begin
                // noise: any opcode, any field value
                if ($urandom_range(1) == 1) begin
                    gen_time = $urandom;
                end
                queue_cmd(t_opcode'($urandom_range(3)), 5'($urandom), 9'($urandom),
                          24'($urandom), gen_time);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        // longest tick plus reply, with margin
        repeat (13 * (NCH + 1) + 40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/mvf_pkg.sv
rtl/core/mvf_ram.sv
rtl/core/mvf_fade_calc.sv
rtl/core/multichannel_volume_fader_unit.sv
tb/multichannel_volume_fader_unit_test.sv
